// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, pre, post, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/fft_pkg.sv -----
// ----------------------------------------------------------------------------
// FFT package
// Shared constants, queue entry type and twiddle helper functions.
// ----------------------------------------------------------------------------
package fft_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = 6;
    localparam int CNT_W      = 7;
    localparam int DATA_W     = 22;
    localparam int SAMPLE_W   = 16;
    localparam int TW_W       = 17;
    localparam int PROD_W     = DATA_W + TW_W;
    localparam int QPTR_W     = 2;

    localparam logic [2:0] REG_INVERSE = 3'd0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic [ADDR_W-1:0]          addr;
        logic                       wr;
        logic                       last;
        logic [CNT_W-1:0]           cnt;
        logic                       trunc;
    } fft_entry_t;

    // Quarter-wave cosine, 1.0 = 32768, steps of 1/64 of a turn.
    function automatic logic signed [TW_W-1:0] fft_quarter_cos(input logic [4:0] r);
        logic signed [TW_W-1:0] v;
        case (r)
            5'd0:    v = 17'sd32768;
            5'd1:    v = 17'sd32610;
            5'd2:    v = 17'sd32138;
            5'd3:    v = 17'sd31357;
            5'd4:    v = 17'sd30274;
            5'd5:    v = 17'sd28899;
            5'd6:    v = 17'sd27246;
            5'd7:    v = 17'sd25330;
            5'd8:    v = 17'sd23170;
            5'd9:    v = 17'sd20788;
            5'd10:   v = 17'sd18205;
            5'd11:   v = 17'sd15447;
            5'd12:   v = 17'sd12540;
            5'd13:   v = 17'sd9512;
            5'd14:   v = 17'sd6393;
            5'd15:   v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [TW_W-1:0] fft_cos64(input logic [ADDR_W-1:0] m);
        logic [4:0] r;
        logic [4:0] rc;
        logic signed [TW_W-1:0] v;
        r  = {1'b0, m[3:0]};
        rc = 5'd16 - r;
        case (m[5:4])
            2'd0:    v = fft_quarter_cos(r);
            2'd1:    v = -fft_quarter_cos(rc);
            2'd2:    v = -fft_quarter_cos(r);
            default: v = fft_quarter_cos(rc);
        endcase
        return v;
    endfunction

    // Number of address bits for the smallest power of two holding cnt points.
    function automatic logic [2:0] fft_log2_ceil(input logic [CNT_W-1:0] cnt);
        logic [2:0] b;
        b = 3'd0;
        for (int k = 0; k < ADDR_W; k++) begin
            if (cnt > (CNT_W'(1) << k))
                b = 3'(k + 1);
        end
        return b;
    endfunction

    // Reverse the low "bits" bits of i.
    function automatic logic [ADDR_W-1:0] fft_bit_rev(input logic [ADDR_W-1:0] i,
                                                      input logic [2:0] bits);
        logic [ADDR_W-1:0] rv;
        for (int k = 0; k < ADDR_W; k++)
            rv[k] = i[ADDR_W-1-k];
        return rv >> (3'(ADDR_W) - bits);
    endfunction

    function automatic logic signed [DATA_W-1:0] fft_sat(input logic signed [DATA_W+4:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 27'sd2097151)
            r = 22'sd2097151;
        else if (v < -27'sd2097152)
            r = -22'sd2097152;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/fft_front.sv -----
// ----------------------------------------------------------------------------
// FFT front end
// Accepts samples, counts the set, marks dropped samples and the set end.
// ----------------------------------------------------------------------------
module fft_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [15:0]        in_re,
    input  logic [15:0]        in_im,
    input  logic               in_last,
    output logic               in_ready,
    input  logic               q_full,
    output logic               q_push,
    output fft_pkg::fft_entry_t q_entry
);
    import fft_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             store;
    logic [CNT_W-1:0] cnt_after;

    assign in_ready  = !q_full;
    assign q_push    = in_valid && !q_full;
    assign store     = count_reg < CNT_W'(MAX_POINTS);
    assign cnt_after = store ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        q_entry.re    = in_re;
        q_entry.im    = in_im;
        q_entry.addr  = count_reg[ADDR_W-1:0];
        q_entry.wr    = store;
        q_entry.last  = in_last;
        q_entry.cnt   = cnt_after;
        q_entry.trunc = ovf_reg || !store;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        if (q_push)
        begin
            if (in_last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = cnt_after;
                ovf_next   = ovf_reg || !store;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ----- rtl/fft_queue.sv -----
// ----------------------------------------------------------------------------
// FFT queue
// Four-entry FIFO between the front end and the transform core.
// ----------------------------------------------------------------------------
module fft_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fft_pkg::fft_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output fft_pkg::fft_entry_t head
);
    import fft_pkg::*;

    fft_entry_t          slots [2**QPTR_W];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;

    assign full  = fill_reg == (QPTR_W+1)'(2**QPTR_W);
    assign empty = fill_reg == '0;
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- rtl/fft_core.sv -----
// ----------------------------------------------------------------------------
// FFT core
// Sample store, bit-reversed copy, shared butterfly unit and result emit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fft_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                inverse,
    input  logic                q_empty,
    input  fft_pkg::fft_entry_t q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [21:0]         out_re,
    output logic [21:0]         out_im,
    output logic                out_last,
    output logic                out_trunc
);
    import fft_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PERM_RD, ST_PERM_WR, ST_BF_RD, ST_BF_MUL,
        ST_BF_ADD, ST_BF_WRB, ST_EMIT_RD, ST_EMIT_WAIT
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [2:0]        stage_reg;
    logic [2:0]        bits_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              trunc_reg;
    logic              out_valid_reg;
    logic              out_last_reg;

    // Sample store (natural order) and work store (transform in place).
    logic [2*DATA_W-1:0] mem_a [2**ADDR_W];
    logic [2*DATA_W-1:0] mem_b [2**ADDR_W];

    logic [2*DATA_W-1:0] rda_reg, rd1_reg, rd2_reg, bres_reg;
    logic                pad_reg;
    logic signed [TW_W-1:0]   c_reg, s_reg;
    logic signed [PROD_W-1:0] p_rc_reg, p_is_reg, p_rs_reg, p_ic_reg;

    logic [CNT_W-1:0]  n_pts;
    logic [ADDR_W-1:0] last_idx, last_bf;
    logic [ADDR_W-1:0] rev_addr, half, mask, addr_a, addr_b, rd1_addr, tw_m;
    logic signed [TW_W-1:0] cos_v, sin_v;
    logic signed [PROD_W+1:0] pr_full, pi_full;
    logic signed [DATA_W+3:0] pr, pi;
    logic signed [DATA_W-1:0] ar, ai, br, bi;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [2*DATA_W-1:0] wr_data;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign n_pts    = CNT_W'(1) << bits_reg;
    assign last_idx = ADDR_W'(n_pts - 1'b1);
    assign last_bf  = ADDR_W'((n_pts >> 1) - 1'b1);
    assign rev_addr = fft_bit_rev(idx_reg, bits_reg);
    assign half     = ADDR_W'(1) << stage_reg;
    assign mask     = half - 1'b1;
    assign addr_a   = ((idx_reg & ~mask) << 1) | (idx_reg & mask);
    assign addr_b   = addr_a | half;
    assign tw_m     = (idx_reg & mask) << (3'd5 - stage_reg);
    assign cos_v    = fft_cos64(tw_m);
    assign sin_v    = fft_cos64(tw_m + 6'd48);
    assign rd1_addr = (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_WAIT) ? idx_reg : addr_a;

    assign ar = rd1_reg[DATA_W-1:0];
    assign ai = rd1_reg[2*DATA_W-1:DATA_W];
    assign br = rd2_reg[DATA_W-1:0];
    assign bi = rd2_reg[2*DATA_W-1:DATA_W];

    // Twiddle product, rounded half up by an arithmetic shift.
    assign pr_full = (PROD_W+2)'(p_rc_reg) - (PROD_W+2)'(p_is_reg) + (PROD_W+2)'(16384);
    assign pi_full = (PROD_W+2)'(p_rs_reg) + (PROD_W+2)'(p_ic_reg) + (PROD_W+2)'(16384);
    assign pr      = pr_full[PROD_W+1:15];
    assign pi      = pi_full[PROD_W+1:15];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = pad_reg ? '0 : rda_reg;
        case (state_reg)
            ST_PERM_WR:
            begin
                wr_en = 1'b1;
            end
            ST_BF_ADD:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_a;
                wr_data = {fft_sat(27'(ai) + 27'(pi)), fft_sat(27'(ar) + 27'(pr))};
            end
            ST_BF_WRB:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_b;
                wr_data = bres_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.wr)
            mem_a[q_head.addr] <= {{(DATA_W-SAMPLE_W){q_head.im[SAMPLE_W-1]}}, q_head.im,
                                   {(DATA_W-SAMPLE_W){q_head.re[SAMPLE_W-1]}}, q_head.re};
        rda_reg <= mem_a[rev_addr];
        pad_reg <= {1'b0, rev_addr} >= cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_b[wr_addr] <= wr_data;
        rd1_reg  <= mem_b[rd1_addr];
        rd2_reg  <= mem_b[addr_b];
        c_reg    <= cos_v;
        s_reg    <= inverse ? -sin_v : sin_v;
        p_rc_reg <= br * c_reg;
        p_is_reg <= bi * s_reg;
        p_rs_reg <= br * s_reg;
        p_ic_reg <= bi * c_reg;
        bres_reg <= {fft_sat(27'(ai) - 27'(pi)), fft_sat(27'(ar) - 27'(pr))};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            stage_reg     <= '0;
            bits_reg      <= '0;
            cnt_reg       <= '0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop && q_head.last)
                    begin
                        bits_reg  <= fft_log2_ceil(q_head.cnt);
                        cnt_reg   <= q_head.cnt;
                        trunc_reg <= q_head.trunc;
                        idx_reg   <= '0;
                        state_reg <= ST_PERM_RD;
                    end
                end
                ST_PERM_RD:
                begin
                    state_reg <= ST_PERM_WR;
                end
                ST_PERM_WR:
                begin
                    if (idx_reg == last_idx)
                    begin
                        idx_reg   <= '0;
                        stage_reg <= '0;
                        state_reg <= (bits_reg == 3'd0) ? ST_EMIT_RD : ST_BF_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_PERM_RD;
                    end
                end
                ST_BF_RD:
                begin
                    state_reg <= ST_BF_MUL;
                end
                ST_BF_MUL:
                begin
                    state_reg <= ST_BF_ADD;
                end
                ST_BF_ADD:
                begin
                    state_reg <= ST_BF_WRB;
                end
                ST_BF_WRB:
                begin
                    if (idx_reg == last_bf)
                    begin
                        idx_reg <= '0;
                        if (stage_reg == bits_reg - 1'b1)
                            state_reg <= ST_EMIT_RD;
                        else
                        begin
                            stage_reg <= stage_reg + 1'b1;
                            state_reg <= ST_BF_RD;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_BF_RD;
                    end
                end
                ST_EMIT_RD:
                begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= idx_reg == last_idx;
                    state_reg     <= ST_EMIT_WAIT;
                end
                ST_EMIT_WAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = rd1_reg[DATA_W-1:0];
    assign out_im    = rd1_reg[2*DATA_W-1:DATA_W];
    assign out_last  = out_last_reg;
    assign out_trunc = trunc_reg;

    `ASSERT_IMPLIES(a_valid_in_wait, out_valid_reg, state_reg == ST_EMIT_WAIT, "result shown outside emit")
    `ASSERT_IMPLIES(a_stage_range, state_reg == ST_BF_RD, stage_reg < bits_reg, "butterfly stage out of range")
    `ASSERT_NEXT(a_drop_after_take, out_valid_reg && out_ready, !out_valid_reg, "result held after transaction")

endmodule

// ----- rtl/radix2_fft_engine.sv -----
// Order of work: once the closing sample is taken, the core copies the set in bit-reversed
// order, runs (N/2)*log2(N) butterflies, each through its read, multiply, add and write-back
// states, then emits the points, each held until taken and only then another read. Input takes
// one sample per cycle while the core is idle, and up to four more wait in the queue while
// the core is busy. Reset: rst_n clears all control state and the inverse register; store
// contents stay undefined until written and are never read before that.
// ----------------------------------------------------------------------------
// Radix-2 FFT engine
// Loads up to 64 complex samples, runs an in-place decimation-in-time FFT on
// the zero-padded power-of-two set and streams the points in natural order.
// ----------------------------------------------------------------------------
module radix2_fft_engine
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: tdata = sample_re[15:0], sample_im[31:16]; tlast = sample_last.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    // Output stream: tdata = point_re[21:0], point_im[43:22], zeros above;
    // tlast = point_last; tuser = truncated.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fft_pkg::*;

    logic       inverse_reg, inverse_next;
    logic       q_full, q_push, q_pop, q_empty;
    fft_entry_t q_entry, q_head;
    logic [21:0] point_re, point_im;

    // Only register 0 (inverse) exists; only paddr[2] is decoded, so addresses 1 to 3
    // alias it, and with paddr[2] set the address selects a nonexistent register and such writes are ignored.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INVERSE[2]) ? {31'd0, inverse_reg} : 32'd0;

    always_comb
    begin
        inverse_next = inverse_reg;
        if (psel && penable && pwrite && paddr[2] == REG_INVERSE[2])
            inverse_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inverse_reg <= 1'b0;
        else
            inverse_reg <= inverse_next;
    end

    // The front end classifies each input transaction (store or drop, set end)
    // and hands it to the core through a short queue, so input keeps flowing
    // while the core is busy with the previous set.
    fft_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_re    (s_tdata[15:0]),
        .in_im    (s_tdata[31:16]),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    fft_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    fft_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .inverse   (inverse_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_re    (point_re),
        .out_im    (point_im),
        .out_last  (m_tlast),
        .out_trunc (m_tuser)
    );

    assign m_tdata = {4'd0, point_im, point_re};

endmodule

// ----- tb/radix2_fft_engine_test.sv -----
// ----------------------------------------------------------------------------
// Radix-2 FFT engine testbench
// Streams sets of complex samples into the engine and checks every
// transformed point against a behavioral FFT kept in this file. Sets of many
// sizes run under both transform directions, with random gaps and stalls on
// both streams.
// ----------------------------------------------------------------------------
module radix2_fft_engine_test;
    import fft_pkg::*;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
    } sample_t;

    typedef struct {
        logic signed [21:0] re;
        logic signed [21:0] im;
        logic               last;
        logic               trunc;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // sample_re [15:0], sample_im [31:16]
    logic        s_tlast;     // sample_last
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;     // point_re [21:0], point_im [43:22], zeros above
    logic        m_tlast;     // point_last
    logic        m_tuser;     // truncated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    radix2_fft_engine u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Samples waiting to be driven, and transformed points waiting to arrive.
    sample_t sample_q[$];
    point_t  spectrum_q[$];

    // Shadow of the engine state used to predict the spectrum.
    logic signed [21:0] store_re[64];
    logic signed [21:0] store_im[64];
    int                 held_count;
    logic               dropped;
    logic               inverse_mode;

    int  errors;
    int  sets_closed;
    int  samples_sent;
    int  points_seen;
    int  truncated_sets;
    bit  in_fire;
    bit  hold_off;
    bit  quiet;
    int  send_gap;
    int  recv_gap;

    // Cosine table over a quarter turn, 1.0 = 32768, steps of 1/64 of a turn.
    localparam int QCOS[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                                23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    function automatic longint turn_cos(input int m);
        int q;
        int r;
        q = (m >> 4) & 3;
        r = m & 15;
        case (q)
            0:       return QCOS[r];
            1:       return -QCOS[16 - r];
            2:       return -QCOS[r];
            default: return QCOS[16 - r];
        endcase
    endfunction

    function automatic logic signed [21:0] clamp22(input longint v);
        if (v > 2097151)
            return 22'sd2097151;
        if (v < -2097152)
            return -22'sd2097152;
        return v[21:0];
    endfunction

    // Most gaps are zero or short; a few are long. Quiet phases have none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Store one accepted sample; on the closing sample transform the set and
    // queue every point in natural order.
    task automatic predict_spectrum(input sample_t smp);
        longint tr[64];
        longint ti[64];
        longint c;
        longint s;
        longint pr;
        longint pim;
        longint ar;
        longint ai;
        int     n;
        int     bits;
        int     rv;
        int     len;
        int     half;
        int     a;
        int     b;
        point_t pt;
        if (held_count < MAX_POINTS) begin
            store_re[held_count] = smp.re;
            store_im[held_count] = smp.im;
            held_count++;
        end
        else
            dropped = 1'b1;
        if (!smp.last)
            return;
        n = 1;
        bits = 0;
        while (n < held_count) begin
            n = n << 1;
            bits++;
        end
        for (int i = held_count; i < n; i++) begin
            store_re[i] = '0;
            store_im[i] = '0;
        end
        // Bit-reversed load, then the butterfly stages in place.
        for (int i = 0; i < n; i++) begin
            rv = 0;
            for (int k = 0; k < bits; k++)
                if (i & (1 << k))
                    rv |= 1 << (bits - 1 - k);
            tr[i] = store_re[rv];
            ti[i] = store_im[rv];
        end
        for (len = 2; len <= n; len = len << 1) begin
            half = len >> 1;
            for (int start = 0; start < n; start += len) begin
                for (int i = 0; i < half; i++) begin
                    a = start + i;
                    b = a + half;
                    c = turn_cos(i * (64 / len));
                    s = turn_cos(i * (64 / len) + 48);
                    if (inverse_mode)
                        s = -s;
                    // Round half up: floor((p + 2^14) / 2^15).
                    pr  = (tr[b] * c - ti[b] * s + 16384) >>> 15;
                    pim = (tr[b] * s + ti[b] * c + 16384) >>> 15;
                    ar = tr[a];
                    ai = ti[a];
                    tr[a] = clamp22(ar + pr);
                    ti[a] = clamp22(ai + pim);
                    tr[b] = clamp22(ar - pr);
                    ti[b] = clamp22(ai - pim);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            pt.re    = tr[i][21:0];
            pt.im    = ti[i][21:0];
            pt.last  = (i == n - 1);
            pt.trunc = dropped;
            spectrum_q.push_back(pt);
        end
        sets_closed++;
        if (dropped)
            truncated_sets++;
        held_count = 0;
        dropped = 1'b0;
    endtask

    // Queue one set; kind 0 is random content, 1 all maximum, 2 all minimum,
    // 3 alternating extremes.
    task automatic queue_set(input int count, input int kind);
        sample_t smp;
        for (int i = 0; i < count; i++) begin
            case (kind)
                1: begin smp.re = 16'sh7fff; smp.im = 16'sh7fff; end
                2: begin smp.re = 16'sh8000; smp.im = 16'sh8000; end
                3: begin
                    smp.re = (i % 2) ? 16'sh8000 : 16'sh7fff;
                    smp.im = (i % 2) ? 16'sh7fff : 16'sh8000;
                end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        smp.re = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
                        smp.im = ($urandom_range(0, 1)) ? 16'sh0000 : 16'shffff;
                    end
                    else begin
                        smp.re = 16'($urandom);
                        smp.im = 16'($urandom);
                    end
                end
            endcase
            smp.last = (i == count - 1);
            sample_q.push_back(smp);
        end
    endtask

    // Wait until every sample is in and every point is out, then let the
    // engine settle before the register is touched.
    task automatic wait_idle();
        while (sample_q.size() != 0 || s_tvalid || spectrum_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_inverse(input logic value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_INVERSE;
        pwdata  <= {31'b0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        inverse_mode = value;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Sender: the next sample goes out only after the current one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire)) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap--;
            end
            else if (sample_q.size() != 0) begin
                sample_t smp;
                smp = sample_q.pop_front();
                s_tdata  <= {smp.im, smp.re};
                s_tlast  <= smp.last;
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus the long hold-off when it is requested.
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (hold_off)
                m_tready <= 1'b0;
            else if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap--;
            end
            else begin
                m_tready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // Monitor: feed accepted samples to the predictor and check every point.
    always @(posedge clk)
    begin
        point_t want;
        in_fire = s_tvalid && s_tready;
        if (in_fire) begin
            sample_t smp;
            smp.re   = s_tdata[15:0];
            smp.im   = s_tdata[31:16];
            smp.last = s_tlast;
            samples_sent++;
            predict_spectrum(smp);
        end
        if (m_tvalid && m_tready) begin
            points_seen++;
            if (spectrum_q.size() == 0) begin
                $display("%0t: unexpected point re=%0d im=%0d last=%0b trunc=%0b", $time,
                         $signed(m_tdata[21:0]), $signed(m_tdata[43:22]), m_tlast, m_tuser);
                errors++;
            end
            else begin
                want = spectrum_q.pop_front();
                if (m_tdata[21:0] !== want.re || m_tdata[43:22] !== want.im ||
                    m_tlast !== want.last || m_tuser !== want.trunc) begin
                    $display("%0t: point mismatch expected re=%0d im=%0d last=%0b trunc=%0b",
                             $time, want.re, want.im, want.last, want.trunc);
                    $display("%0t:                actual re=%0d im=%0d last=%0b trunc=%0b",
                             $time, $signed(m_tdata[21:0]), $signed(m_tdata[43:22]),
                             m_tlast, m_tuser);
                    errors++;
                end
            end
        end
    end

    // The receiver stops for a long stretch while samples keep coming, so the
    // engine fills up and pushes back on its input.
    initial
    begin
        hold_off = 1'b0;
        while (samples_sent < 150)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        int r;
        int size;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        errors = 0;
        sets_closed = 0;
        samples_sent = 0;
        points_seen = 0;
        truncated_sets = 0;
        held_count = 0;
        dropped = 1'b0;
        inverse_mode = 1'b0;
        quiet = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: single sample, smallest sets, padding, extremes.
        queue_set(1, 1);
        queue_set(1, 2);
        queue_set(2, 3);
        queue_set(3, 1);
        queue_set(4, 2);
        queue_set(5, 0);
        queue_set(8, 3);
        wait_idle();
        write_inverse(1'b1);
        queue_set(1, 0);
        queue_set(4, 3);
        queue_set(64, 1);
        wait_idle();
        write_inverse(1'b0);
        // Full store of extremes, then overflow, then a set whose closing
        // sample is itself dropped.
        queue_set(64, 2);
        queue_set(64, 3);
        queue_set(67, 0);
        queue_set(65, 3);

        // Random phases, alternating the transform direction.
        for (int phase = 1; phase <= 3; phase++) begin
            wait_idle();
            write_inverse(phase % 2);
            quiet = (phase == 3);
            size = 0;
            while (size < 50) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    r = $urandom_range(1, 8);
                else if (r < 90)
                    r = $urandom_range(9, 32);
                else if (r < 97)
                    r = $urandom_range(33, 64);
                else
                    r = $urandom_range(65, 70);
                queue_set(r, 0);
                size += r;
            end
        end
        wait_idle();

        $display("Covered %0d sets, %0d samples, %0d points, %0d truncated sets,",
                 sets_closed, samples_sent, points_seen, truncated_sets);
        $display("under both transform directions with stalls on both streams.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fft_pkg.sv
rtl/fft_front.sv
rtl/fft_queue.sv
rtl/fft_core.sv
rtl/radix2_fft_engine.sv
tb/radix2_fft_engine_test.sv
